// File: design/tgd_pkg.sv
package tgd_pkg;

  localparam int unsigned HoldCount   = 50;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TabLen      = 24;
  localparam int unsigned StepW       = $clog2(TabLen);

  localparam int unsigned DataW  = 44;
  localparam int unsigned AngW   = 26;
  localparam int unsigned AtanW  = 22;
  localparam int unsigned MagW   = 27;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned QW     = 18;
  localparam int unsigned GainQ16 = 107922;
  localparam int unsigned Deg90   = 90 * 65536;

  localparam int unsigned PitchW   = 14;
  localparam int unsigned RollW    = 15;
  localparam int unsigned StageW   = 2;
  localparam int unsigned HoldW    = 6;
  localparam int unsigned PitchMax = 11520;
  localparam int unsigned RollMax  = 23040;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam logic [StageW-1:0] StageFlat  = 2'd0;
  localparam logic [StageW-1:0] StageSlant = 2'd1;
  localparam logic [StageW-1:0] StageFlat2 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_NEXT,
    ST_DECIDE
  } state_e;

  typedef enum logic {
    PASS_ROLL,
    PASS_PITCH
  } pass_e;

  typedef enum logic [2:0] {
    REG_FLAT_PITCH_LOW,
    REG_FLAT_PITCH_HIGH,
    REG_FLAT_ROLL_LOW,
    REG_FLAT_ROLL_HIGH,
    REG_SLANT_PITCH_LOW,
    REG_SLANT_PITCH_HIGH,
    REG_SLANT_ROLL_LOW,
    REG_SLANT_ROLL_HIGH
  } cfg_idx_e;

  typedef struct packed {
    logic [PitchW-1:0] pitch_low;
    logic [PitchW-1:0] pitch_high;
    logic [RollW-1:0]  roll_low;
    logic [RollW-1:0]  roll_high;
  } window_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic [AtanW-1:0] atan_lut(input logic [StepW-1:0] idx);
    logic [AtanW-1:0] r;
    unique case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/tilt_gesture_detector_unit.sv
// Tilt gesture detector. Each accelerometer word (x, y, z) yields one result word with
// |pitch| and |roll| in degrees times 128, the stage after this sample (flat, slant,
// flat again), the hold counter, and flags for a completed stage and a completed
// gesture. Both angles come from a single shared CORDIC vectoring unit that runs a roll
// pass and then a pitch pass of 16 micro-rotations each. After a sample is accepted, each
// pass loads its vector, rotates and wraps up; then the window check writes the result
// once the output register is free. A pass whose vector is zero skips its rotations. The
// input is not ready while a sample is in work; the result sits in an output register and
// the next sample is taken while it waits. Window registers are to be written over the
// APB port only while the block is idle; the block itself does not enforce this.
module tilt_gesture_detector_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // accel_x, accel_y, accel_z
  input  logic [tgd_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pitch_abs, roll_abs, stage_now, hold_value, stage_advanced, gesture_done, zero pad
  output logic [tgd_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tgd_pkg::CfgAddrW-1:0]     paddr,
  input  logic [tgd_pkg::CfgDataW-1:0]     pwdata,
  output logic [tgd_pkg::CfgDataW-1:0]     prdata,
  output logic                             pready
);
  import tgd_pkg::*;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;

  logic signed [15:0]      ax_q, ay_q, az_q;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic signed [MagW-1:0]  mag_q, mag_d;
  logic signed [DataW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0]  ang_q, ang_d;
  logic [StepW-1:0]        step_q, step_d;
  logic [RollW-1:0]        roll_q, roll_d;
  logic [PitchW-1:0]       pitch_q, pitch_d;
  logic [StageW-1:0]       stage_q, stage_d;
  logic [HoldW-1:0]        hold_q, hold_d;
  logic                    m_tvalid_q, m_tvalid_d;
  logic [OutDataW-1:0]     m_tdata_q, m_tdata_d;

  window_t flat_q, slant_q, win;

  logic                    in_accept, slot_free, last_step, vec_zero;
  logic signed [DataW-1:0] x_in, y_in, x_sh, y_sh;
  logic [16:0]             ax_abs;
  logic [AngW-1:0]         ang_abs;
  logic [AngW:0]           ang_sum;
  logic [QW-1:0]           ang_q7;
  logic                    in_win, advanced, done;
  logic [StageW-1:0]       stage_nx;
  logic [HoldW-1:0]        hold_nx;
  logic                    cfg_we;
  cfg_idx_e                cfg_idx;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_tvalid_q || m_axis_tready;
  assign last_step     = (step_q == StepW'(CordicSteps - 1));
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // vector feeding the shared unit for the current pass
  always_comb begin
    if (pass_q == PASS_ROLL) begin
      x_in = {{(DataW - 24){az_q[15]}}, az_q, 8'b0};
      y_in = {{(DataW - 24){ay_q[15]}}, ay_q, 8'b0};
    end else begin
      x_in = {{(DataW - MagW - 16){mag_q[MagW-1]}}, mag_q, 16'b0};
      y_in = signed'(DataW'({prod_q, 8'b0}));
    end
  end

  assign vec_zero = (x_in == '0) && (y_in == '0);
  assign ax_abs   = ax_q[15] ? (17'd0 - {ax_q[15], ax_q}) : {1'b0, ax_q};
  assign x_sh     = x_q >>> step_q;
  assign y_sh     = y_q >>> step_q;

  // round the accumulated angle to degrees times 128
  assign ang_abs = ang_q[AngW-1] ? AngW'(-ang_q) : AngW'(ang_q);
  assign ang_sum = {1'b0, ang_abs} + (AngW + 1)'(256);
  assign ang_q7  = ang_sum[AngW:9];

  assign win = (stage_q == StageSlant) ? slant_q : flat_q;

  always_comb begin
    in_win = (pitch_q >= win.pitch_low) && (pitch_q <= win.pitch_high) &&
             (roll_q >= win.roll_low) && (roll_q <= win.roll_high);
    advanced = 1'b0;
    done     = 1'b0;
    stage_nx = stage_q;
    hold_nx  = hold_q;
    if (in_win) begin
      if (hold_q < HoldW'(HoldCount)) begin
        hold_nx = hold_q + 1'b1;
      end else begin
        hold_nx  = '0;
        advanced = 1'b1;
        done     = (stage_q == StageFlat2);
        stage_nx = (stage_q >= StageFlat2) ? StageFlat : stage_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_PREP;
      ST_PREP:   state_d = vec_zero ? ST_NEXT : ST_ITER;
      ST_ITER:   if (last_step) state_d = ST_NEXT;
      ST_NEXT:   state_d = (pass_q == PASS_ROLL) ? ST_PREP : ST_DECIDE;
      ST_DECIDE: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pass_d     = pass_q;
    prod_d     = prod_q;
    mag_d      = mag_q;
    x_d        = x_q;
    y_d        = y_q;
    ang_d      = ang_q;
    step_d     = step_q;
    roll_d     = roll_q;
    pitch_d    = pitch_q;
    stage_d    = stage_q;
    hold_d     = hold_q;
    m_tdata_d  = m_tdata_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        pass_d = PASS_ROLL;
      end
      ST_PREP: begin
        step_d = '0;
        if (pass_q == PASS_ROLL) prod_d = ProdW'(ax_abs) * ProdW'(GainQ16);
        if (vec_zero) begin
          x_d   = '0;
          y_d   = '0;
          ang_d = '0;
        end else if (!x_in[DataW-1]) begin
          x_d   = x_in;
          y_d   = y_in;
          ang_d = '0;
        end else if (!y_in[DataW-1]) begin
          x_d   = y_in;
          y_d   = -x_in;
          ang_d = AngW'(Deg90);
        end else begin
          x_d   = -y_in;
          y_d   = x_in;
          ang_d = -AngW'(Deg90);
        end
      end
      ST_ITER: begin
        step_d = step_q + 1'b1;
        if (!y_q[DataW-1]) begin
          x_d   = x_q + y_sh;
          y_d   = y_q - x_sh;
          ang_d = ang_q + signed'(AngW'(atan_lut(step_q)));
        end else begin
          x_d   = x_q - y_sh;
          y_d   = y_q + x_sh;
          ang_d = ang_q - signed'(AngW'(atan_lut(step_q)));
        end
      end
      ST_NEXT: begin
        if (pass_q == PASS_ROLL) begin
          roll_d = (ang_q7 > QW'(RollMax)) ? RollW'(RollMax) : ang_q7[RollW-1:0];
          mag_d  = x_q[MagW-1:0];
          pass_d = PASS_PITCH;
        end else begin
          pitch_d = (ang_q7 > QW'(PitchMax)) ? PitchW'(PitchMax) : ang_q7[PitchW-1:0];
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          stage_d    = stage_nx;
          hold_d     = hold_nx;
          m_tvalid_d = 1'b1;
          m_tdata_d  = {1'b0, done, advanced, hold_nx, stage_nx, roll_q, pitch_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pass_q     <= PASS_ROLL;
      step_q     <= '0;
      stage_q    <= StageFlat;
      hold_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      step_q     <= step_d;
      stage_q    <= stage_d;
      hold_q     <= hold_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ax_q <= s_axis_tdata[15:0];
      ay_q <= s_axis_tdata[31:16];
      az_q <= s_axis_tdata[47:32];
    end
    prod_q    <= prod_d;
    mag_q     <= mag_d;
    x_q       <= x_d;
    y_q       <= y_d;
    ang_q     <= ang_d;
    roll_q    <= roll_d;
    pitch_q   <= pitch_d;
    m_tdata_q <= m_tdata_d;
  end

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_q.pitch_low   <= '0;
      flat_q.pitch_high  <= PitchW'(640);
      flat_q.roll_low    <= '0;
      flat_q.roll_high   <= RollW'(640);
      slant_q.pitch_low  <= '0;
      slant_q.pitch_high <= PitchW'(640);
      slant_q.roll_low   <= RollW'(5120);
      slant_q.roll_high  <= RollW'(6400);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FLAT_PITCH_LOW:   flat_q.pitch_low   <= pwdata[PitchW-1:0];
        REG_FLAT_PITCH_HIGH:  flat_q.pitch_high  <= pwdata[PitchW-1:0];
        REG_FLAT_ROLL_LOW:    flat_q.roll_low    <= pwdata[RollW-1:0];
        REG_FLAT_ROLL_HIGH:   flat_q.roll_high   <= pwdata[RollW-1:0];
        REG_SLANT_PITCH_LOW:  slant_q.pitch_low  <= pwdata[PitchW-1:0];
        REG_SLANT_PITCH_HIGH: slant_q.pitch_high <= pwdata[PitchW-1:0];
        REG_SLANT_ROLL_LOW:   slant_q.roll_low   <= pwdata[RollW-1:0];
        REG_SLANT_ROLL_HIGH:  slant_q.roll_high  <= pwdata[RollW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FLAT_PITCH_LOW:   prdata = CfgDataW'(flat_q.pitch_low);
      REG_FLAT_PITCH_HIGH:  prdata = CfgDataW'(flat_q.pitch_high);
      REG_FLAT_ROLL_LOW:    prdata = CfgDataW'(flat_q.roll_low);
      REG_FLAT_ROLL_HIGH:   prdata = CfgDataW'(flat_q.roll_high);
      REG_SLANT_PITCH_LOW:  prdata = CfgDataW'(slant_q.pitch_low);
      REG_SLANT_PITCH_HIGH: prdata = CfgDataW'(slant_q.pitch_high);
      REG_SLANT_ROLL_LOW:   prdata = CfgDataW'(slant_q.roll_low);
      REG_SLANT_ROLL_HIGH:  prdata = CfgDataW'(slant_q.roll_high);
      default:              prdata = '0;
    endcase
  end

  a_result_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_DECIDE))
    else $error("result raised outside the window check");

  a_hold_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q <= HoldW'(HoldCount))
    else $error("hold counter beyond its limit");

  a_stage_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != 2'd3)
    else $error("unused stage code reached");

  a_done_implies_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tdata_q[38]) |-> (m_tdata_q[37] && m_tdata_q[30:29] == StageFlat))
    else $error("gesture flagged without wrap to first stage");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (step_q < StepW'(CordicSteps)))
    else $error("rotation step out of range");

endmodule

// File: bench/tilt_gesture_detector_unit_tb.sv
`timescale 1ns / 1ps

module tilt_gesture_detector_unit_tb;

  typedef struct packed {
    logic                       pad;
    logic                       gesture_done;
    logic                       stage_advanced;
    logic [tgd_pkg::HoldW-1:0]  hold_value;
    logic [tgd_pkg::StageW-1:0] stage_now;
    logic [tgd_pkg::RollW-1:0]  roll_abs;
    logic [tgd_pkg::PitchW-1:0] pitch_abs;
  } result_t;

  typedef enum {FEED_AIMED, FEED_PINNED} feed_e;

  localparam longint Gain    = tgd_pkg::GainQ16;
  localparam longint QuarterTurn = tgd_pkg::Deg90;

  class gesture_tracker;
    tgd_pkg::window_t           flat_win, slant_win;
    logic [tgd_pkg::StageW-1:0] stage;
    logic [tgd_pkg::HoldW-1:0]  hold;
    longint                     atan_deg[24];
    result_t                    pending[$];
    int unsigned                errors, samples, results, advances, gestures;

    function new();
      flat_win.pitch_low   = '0;
      flat_win.pitch_high  = 14'd640;
      flat_win.roll_low    = '0;
      flat_win.roll_high   = 15'd640;
      slant_win.pitch_low  = '0;
      slant_win.pitch_high = 14'd640;
      slant_win.roll_low   = 15'd5120;
      slant_win.roll_high  = 15'd6400;
      stage = tgd_pkg::StageFlat;
      hold  = '0;
      atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
    endfunction

    function void write_reg(tgd_pkg::cfg_idx_e idx, int unsigned value);
      case (idx)
        tgd_pkg::REG_FLAT_PITCH_LOW:   flat_win.pitch_low   = value[tgd_pkg::PitchW-1:0];
        tgd_pkg::REG_FLAT_PITCH_HIGH:  flat_win.pitch_high  = value[tgd_pkg::PitchW-1:0];
        tgd_pkg::REG_FLAT_ROLL_LOW:    flat_win.roll_low    = value[tgd_pkg::RollW-1:0];
        tgd_pkg::REG_FLAT_ROLL_HIGH:   flat_win.roll_high   = value[tgd_pkg::RollW-1:0];
        tgd_pkg::REG_SLANT_PITCH_LOW:  slant_win.pitch_low  = value[tgd_pkg::PitchW-1:0];
        tgd_pkg::REG_SLANT_PITCH_HIGH: slant_win.pitch_high = value[tgd_pkg::PitchW-1:0];
        tgd_pkg::REG_SLANT_ROLL_LOW:   slant_win.roll_low   = value[tgd_pkg::RollW-1:0];
        tgd_pkg::REG_SLANT_ROLL_HIGH:  slant_win.roll_high  = value[tgd_pkg::RollW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned reg_value(tgd_pkg::cfg_idx_e idx);
      case (idx)
        tgd_pkg::REG_FLAT_PITCH_LOW:   return flat_win.pitch_low;
        tgd_pkg::REG_FLAT_PITCH_HIGH:  return flat_win.pitch_high;
        tgd_pkg::REG_FLAT_ROLL_LOW:    return flat_win.roll_low;
        tgd_pkg::REG_FLAT_ROLL_HIGH:   return flat_win.roll_high;
        tgd_pkg::REG_SLANT_PITCH_LOW:  return slant_win.pitch_low;
        tgd_pkg::REG_SLANT_PITCH_HIGH: return slant_win.pitch_high;
        tgd_pkg::REG_SLANT_ROLL_LOW:   return slant_win.roll_low;
        default:                       return slant_win.roll_high;
      endcase
    endfunction

    function longint vector_angle(longint vx, longint vy, output longint mag);
      longint ang, t, nx, ny;
      ang = 0;
      if (vx == 0 && vy == 0) begin
        mag = 0;
        return 0;
      end
      if (vx < 0) begin
        t = vx;
        if (vy >= 0) begin
          vx  = vy;
          vy  = -t;
          ang = QuarterTurn;
        end else begin
          vx  = -vy;
          vy  = t;
          ang = -QuarterTurn;
        end
      end
      for (int i = 0; i < tgd_pkg::CordicSteps && i < 24; i++) begin
        if (vy >= 0) begin
          nx  = vx + (vy >>> i);
          ny  = vy - (vx >>> i);
          ang = ang + atan_deg[i];
        end else begin
          nx  = vx - (vy >>> i);
          ny  = vy + (vx >>> i);
          ang = ang - atan_deg[i];
        end
        vx = nx;
        vy = ny;
      end
      mag = vx;
      return ang;
    endfunction

    function longint to_q7(longint ang, longint cap);
      longint q;
      q = ((ang < 0 ? -ang : ang) + 256) >>> 9;
      return q > cap ? cap : q;
    endfunction

    function void measure(logic [47:0] word, output logic [tgd_pkg::PitchW-1:0] pitch,
                          output logic [tgd_pkg::RollW-1:0] roll);
      longint ax, ay, az, mag, spare, roll_ang, pitch_ang, pq, rq;
      ax = $signed(word[15:0]);
      ay = $signed(word[31:16]);
      az = $signed(word[47:32]);
      roll_ang  = vector_angle(az * 256, ay * 256, mag);
      pitch_ang = vector_angle(mag * 65536, (ax < 0 ? -ax : ax) * 256 * Gain, spare);
      pq = to_q7(pitch_ang, tgd_pkg::PitchMax);
      rq = to_q7(roll_ang, tgd_pkg::RollMax);
      pitch = pq[tgd_pkg::PitchW-1:0];
      roll  = rq[tgd_pkg::RollW-1:0];
    endfunction

    function bit window_hit(logic [tgd_pkg::StageW-1:0] st, logic [tgd_pkg::PitchW-1:0] pitch,
                            logic [tgd_pkg::RollW-1:0] roll);
      tgd_pkg::window_t w;
      w = (st == tgd_pkg::StageSlant) ? slant_win : flat_win;
      return pitch >= w.pitch_low && pitch <= w.pitch_high &&
             roll >= w.roll_low && roll <= w.roll_high;
    endfunction

    function void note_sample(logic [47:0] word);
      result_t                    res;
      logic [tgd_pkg::PitchW-1:0] pitch;
      logic [tgd_pkg::RollW-1:0]  roll;
      res = '0;
      measure(word, pitch, roll);
      res.pitch_abs = pitch;
      res.roll_abs  = roll;
      if (window_hit(stage, pitch, roll)) begin
        if (hold < tgd_pkg::HoldCount) begin
          hold = hold + 1'b1;
        end else begin
          hold = '0;
          res.stage_advanced = 1'b1;
          res.gesture_done   = (stage == tgd_pkg::StageFlat2);
          stage = (stage >= tgd_pkg::StageFlat2) ? tgd_pkg::StageFlat : stage + 2'd1;
        end
      end
      res.stage_now  = stage;
      res.hold_value = hold;
      pending.push_back(res);
      samples++;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [tgd_pkg::OutDataW-1:0] word);
      result_t want, got;
      got = word;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, word);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      advances += got.stage_advanced;
      gestures += got.gesture_done;
      check_field("pitch_abs", want.pitch_abs, got.pitch_abs);
      check_field("roll_abs", want.roll_abs, got.roll_abs);
      check_field("stage_now", want.stage_now, got.stage_now);
      check_field("hold_value", want.hold_value, got.hold_value);
      check_field("stage_advanced", want.stage_advanced, got.stage_advanced);
      check_field("gesture_done", want.gesture_done, got.gesture_done);
      check_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [tgd_pkg::InDataW-1:0]     s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [tgd_pkg::OutDataW-1:0]    m_axis_tdata;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [tgd_pkg::CfgAddrW-1:0]    paddr;
  logic [tgd_pkg::CfgDataW-1:0]    pwdata;
  logic [tgd_pkg::CfgDataW-1:0]    prdata;
  logic                            pready;

  gesture_tracker tracker;
  int unsigned    win[8];
  logic [47:0]    pinned_word;
  bit             calm;
  bit             long_hold_req;

  tilt_gesture_detector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk_i);
      end else if (calm || $urandom_range(0, 99) >= 20) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("tilt_gesture_detector_unit regression: fail");
    $finish;
  end

  function automatic logic [47:0] pack_xyz(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [47:0] template_sample(bit slant, bit wild);
    int x, y, z;
    if (wild) return {16'($urandom()), 32'($urandom())};
    z = $urandom_range(6000, 30000);
    x = $urandom_range(0, 2400) - 1200;
    if (slant) begin
      y = z * $urandom_range(20, 100) / 64;
      if (y > 32767) y = 32767;
      if ($urandom_range(0, 1)) y = -y;
    end else begin
      y = $urandom_range(0, 2400) - 1200;
    end
    return pack_xyz(x, y, z);
  endfunction

  // retry, up to 48 candidates, until the sample lands in the current stage's window
  function automatic logic [47:0] aimed_sample();
    logic [47:0]                cand;
    logic [tgd_pkg::PitchW-1:0] pitch;
    logic [tgd_pkg::RollW-1:0]  roll;
    for (int t = 0; t < 48; t++) begin
      cand = template_sample(tracker.stage == tgd_pkg::StageSlant, t % 4 == 3);
      tracker.measure(cand, pitch, roll);
      if (tracker.window_hit(tracker.stage, pitch, roll)) break;
    end
    return cand;
  endfunction

  task automatic send_sample(input logic [47:0] word);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic run_items(input int unsigned n, input feed_e how);
    logic [47:0] word;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) word = template_sample(1'b0, 1'b1);
      else if (how == FEED_PINNED) word = pinned_word;
      else word = aimed_sample();
      send_sample(word);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // write, then read back in the next transfer
  task automatic cfg_write(input tgd_pkg::cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.check_field("prdata", tracker.reg_value(idx), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_windows();
    for (int i = 0; i < 8; i++) cfg_write(tgd_pkg::cfg_idx_e'(i), win[i]);
  endtask

  task automatic random_windows();
    int unsigned lo;
    lo  = $urandom_range(2200, 6000);
    win = '{$urandom_range(0, 256), $urandom_range(384, 2000),
            $urandom_range(0, 256), $urandom_range(384, 2000),
            $urandom_range(0, 256), $urandom_range(384, 2000),
            lo, lo + $urandom_range(600, 3000)};
    apply_windows();
  endtask

  initial begin
    logic [47:0]                directed[20];
    logic [tgd_pkg::PitchW-1:0] pitch;
    logic [tgd_pkg::RollW-1:0]  roll;
    tracker       = new();
    calm          = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed = '{pack_xyz(0, 0, 0), pack_xyz(32767, 0, 0), pack_xyz(-32768, 0, 0),
                 pack_xyz(0, 32767, 0), pack_xyz(0, -32768, 0), pack_xyz(0, 0, 32767),
                 pack_xyz(0, 0, -32768), pack_xyz(32767, 32767, 32767),
                 pack_xyz(-32768, -32768, -32768), pack_xyz(1, 0, 0), pack_xyz(0, 1, -1),
                 pack_xyz(0, -1, -32768), pack_xyz(-100, 5, -100), pack_xyz(100, -5, -100),
                 pack_xyz(0, 0, 16384), pack_xyz(300, -300, 16384),
                 pack_xyz(-300, 300, 16384), pack_xyz(0, 11585, 11585),
                 pack_xyz(0, -11585, 11585), pack_xyz(-1, -1, -1)};
    foreach (directed[i]) send_sample(directed[i]);
    run_items(200, FEED_AIMED);
    drain();

    // open windows: every sample counts, stall the output meanwhile
    win = '{0, 16383, 0, 32767, 0, 16383, 0, 32767};
    apply_windows();
    long_hold_req = 1'b1;
    run_items(150, FEED_AIMED);
    drain();

    // inverted windows: nothing matches, stage and counter hold
    win = '{16383, 0, 32767, 0, 16383, 0, 32767, 0};
    apply_windows();
    run_items(40, FEED_AIMED);
    drain();

    // windows collapsed onto one sample's angles
    pinned_word = template_sample(1'b0, 1'b1);
    tracker.measure(pinned_word, pitch, roll);
    win = '{pitch, pitch, roll, roll, pitch, pitch, roll, roll};
    apply_windows();
    run_items(60, FEED_PINNED);
    drain();

    repeat (3) begin
      random_windows();
      run_items(110, FEED_AIMED);
      drain();
    end

    win = '{0, 640, 0, 640, 0, 640, 5120, 6400};
    apply_windows();
    calm = 1'b1;
    run_items(150, FEED_AIMED);
    drain();

    $display("covered %0d samples and %0d results under eight window settings",
             tracker.samples, tracker.results);
    $display("saw %0d stage advances and %0d completed gestures",
             tracker.advances, tracker.gestures);
    if (tracker.errors == 0) begin
      $display("tilt_gesture_detector_unit regression: pass");
    end else begin
      $display("tilt_gesture_detector_unit regression: fail");
    end
    $finish;
  end

endmodule
